// ----- hdl/mdb_master_transaction_top_macros.svh -----
// ----------------------------------------------------------------------------
// MDB master transaction: assertion macros
// Shared property forms for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef MDB_MASTER_TRANSACTION_TOP_MACROS_SVH
`define MDB_MASTER_TRANSACTION_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MDB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mdb_pkg.sv -----
// ----------------------------------------------------------------------------
// MDB master transaction package
// Word types, result kinds, opcodes and fixed constants of the bus master.
// ----------------------------------------------------------------------------
package mdb_pkg;

    localparam int COUNT_W = 6;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_RX   = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_ANSWER = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic CFG_TIMEOUT  = 1'b0;
    localparam logic CFG_AUTO_ACK = 1'b1;

    localparam logic [8:0]  MODE_BIT      = 9'h100;
    localparam logic [8:0]  ACK_WORD      = 9'h000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         peripheral_address;
        logic [7:0]         command_code;
        logic [COUNT_W-1:0] param_count;
        logic [4:0]         param_index;
        logic [7:0]         param_byte;
        logic [8:0]         rx_word;
    } req_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [8:0]         tx_word;
        logic [7:0]         answer_byte;
        logic [COUNT_W-1:0] answer_index;
        logic [COUNT_W-1:0] reply_length;
        logic               status;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic               load_en;
        logic [4:0]         load_index;
        logic [7:0]         load_data;
        logic               start;
        logic               capture;
        logic [7:0]         first_word;
        logic [COUNT_W-1:0] frame_len;
    } frame_ctrl_t;

    typedef struct packed {
        logic       word_valid;
        logic [8:0] word;
        logic       last;
    } frame_stat_t;

endpackage

// ----- hdl/mdb_frame_tx.sv -----
// ----------------------------------------------------------------------------
// MDB frame transmitter
// Parameter store in a synchronous RAM; walks it to emit first word,
// parameters and sum checksum, one word per accepted cycle.
// ----------------------------------------------------------------------------
module mdb_frame_tx
    import mdb_pkg::*;
#(
    parameter int MAX_PARAMS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_ctrl_t ctrl,
    input  logic        tx_ready,
    output frame_stat_t stat
);

    localparam int ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    typedef enum logic [1:0] {F_IDLE, F_FIRST, F_PARAM, F_SUM} fstate_t;

    fstate_t            state_reg;
    logic [7:0]         first_reg;
    logic [COUNT_W-1:0] len_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic [7:0]         sum_reg;

    logic [7:0]         mem [MAX_PARAMS];
    logic [7:0]         rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COUNT_W-1:0] idx_next;

    assign idx_next = idx_reg + COUNT_W'(1);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            F_FIRST:
            begin
                rd_en   = tx_ready && (len_reg != '0);
                rd_addr = '0;
            end
            F_PARAM:
            begin
                rd_en   = tx_ready && (idx_next != len_reg);
                rd_addr = ADDR_W'(idx_next);
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            mem[ADDR_W'(ctrl.load_index)] <= ctrl.load_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        stat.word_valid = (state_reg != F_IDLE);
        stat.last       = (state_reg == F_SUM);
        case (state_reg)
            F_FIRST: stat.word = MODE_BIT | {1'b0, first_reg};
            F_PARAM: stat.word = {1'b0, rd_data_reg};
            F_SUM:   stat.word = {1'b0, sum_reg};
            default: stat.word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            first_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        if (ctrl.capture)
                        begin
                            first_reg <= ctrl.first_word;
                            len_reg   <= ctrl.frame_len;
                        end
                        state_reg <= F_FIRST;
                    end
                end
                F_FIRST:
                begin
                    if (tx_ready)
                    begin
                        sum_reg   <= first_reg;
                        idx_reg   <= '0;
                        state_reg <= (len_reg == '0) ? F_SUM : F_PARAM;
                    end
                end
                F_PARAM:
                begin
                    if (tx_ready)
                    begin
                        sum_reg   <= sum_reg + rd_data_reg;
                        idx_reg   <= idx_next;
                        if (idx_next == len_reg)
                        begin
                            state_reg <= F_SUM;
                        end
                    end
                end
                F_SUM:
                begin
                    if (tx_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/mdb_master_transaction_top.sv -----
// ----------------------------------------------------------------------------
// MDB master transaction top level
// Bus master for 9-bit multi-drop links: frame send, reply check, one retry.
// ----------------------------------------------------------------------------
// One word is taken at a time. A load, or a received word or tick that causes
// no result, returns no response. A send, or a failure that resends, reads
// the frame (first word, parameters, checksum) from the parameter RAM one
// entry per cycle and sends it through the output register at one word per
// cycle while the result side does not stall. An echoed answer byte gives one
// answer result, a good reply its answer, an ACK word if auto-ACK applies and
// a done word, and a failure that ends the transaction a done word.
`include "mdb_master_transaction_top_macros.svh"

module mdb_master_transaction_top
    import mdb_pkg::*;
#(
    parameter int MAX_PARAMS = 32,
    parameter int MAX_FRAME  = 34
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int SEND_MAX = (MAX_PARAMS < MAX_FRAME - 2) ? MAX_PARAMS : MAX_FRAME - 2;

    typedef enum logic [2:0] {T_IDLE, T_FRAME, T_ANSWER, T_ACK, T_DONE} tstate_t;

    tstate_t            state_reg;
    logic [15:0]        timeout_ticks_reg;
    logic               auto_ack_reg;
    logic               phase_reg;
    logic               retry_used_reg;
    logic [COUNT_W-1:0] rx_count_reg;
    logic [7:0]         rx_sum_reg;
    logic [15:0]        timeout_count_reg;
    logic [7:0]         ans_byte_reg;
    logic [COUNT_W-1:0] ans_index_reg;
    logic               ans_last_reg;
    logic               ack_reg;
    logic [COUNT_W-1:0] done_len_reg;
    logic               done_status_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    frame_ctrl_t        frame_ctrl;
    frame_stat_t        frame_stat;

    logic               accept;
    logic               out_free;
    logic               tx_ready;
    logic               rsp_load;
    logic [7:0]         rx_byte;
    logic               rx_mode;
    logic [COUNT_W:0]   count_inc;
    logic [15:0]        tick_next;
    logic               timed_out;
    logic               fail_now;
    logic [COUNT_W-1:0] count_sat;

    function automatic rsp_t pack_rsp(input logic [1:0]         kind,
                                      input logic [8:0]         tx,
                                      input logic [7:0]         ab,
                                      input logic [COUNT_W-1:0] ai,
                                      input logic [COUNT_W-1:0] len,
                                      input logic               st,
                                      input logic               lst);
        rsp_t r;
        r.result_kind  = kind;
        r.tx_word      = tx;
        r.answer_byte  = ab;
        r.answer_index = ai;
        r.reply_length = len;
        r.status       = st;
        r.last         = lst;
        return r;
    endfunction

    assign req_ready = (state_reg == T_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign tx_ready  = (state_reg == T_FRAME) && out_free;
    assign rsp_load  = out_free && (state_reg != T_IDLE) &&
                       ((state_reg != T_FRAME) || frame_stat.word_valid);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rx_byte   = req.rx_word[7:0];
    assign rx_mode   = req.rx_word[8];
    assign count_inc = {1'b0, rx_count_reg} + (COUNT_W+1)'(1);
    assign tick_next = timeout_count_reg + 16'd1;
    assign timed_out = (timeout_ticks_reg == '0) || (tick_next >= timeout_ticks_reg);
    assign count_sat = (req.param_count > COUNT_W'(SEND_MAX)) ? COUNT_W'(SEND_MAX)
                                                              : req.param_count;

    always_comb
    begin
        fail_now = 1'b0;
        if (accept && phase_reg)
        begin
            case (req.opcode)
                OP_RX:
                    fail_now = rx_mode ? (rx_sum_reg != rx_byte)
                                       : (count_inc >= (COUNT_W+1)'(MAX_FRAME));
                OP_TICK:
                    fail_now = timed_out;
                default:
                    fail_now = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        frame_ctrl.load_en    = accept && (req.opcode == OP_LOAD) &&
                                ({1'b0, req.param_index} < COUNT_W'(MAX_PARAMS));
        frame_ctrl.load_index = req.param_index;
        frame_ctrl.load_data  = req.param_byte;
        frame_ctrl.capture    = accept && (req.opcode == OP_SEND);
        frame_ctrl.start      = frame_ctrl.capture || (fail_now && !retry_used_reg);
        frame_ctrl.first_word = req.peripheral_address + req.command_code;
        frame_ctrl.frame_len  = count_sat;
    end

    mdb_frame_tx #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_frame_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (frame_ctrl),
        .tx_ready (tx_ready),
        .stat     (frame_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            timeout_ticks_reg <= TIMEOUT_RESET;
            auto_ack_reg      <= 1'b1;
            phase_reg         <= 1'b0;
            retry_used_reg    <= 1'b0;
            rx_count_reg      <= '0;
            rx_sum_reg        <= '0;
            timeout_count_reg <= '0;
            ans_byte_reg      <= '0;
            ans_index_reg     <= '0;
            ans_last_reg      <= 1'b0;
            ack_reg           <= 1'b0;
            done_len_reg      <= '0;
            done_status_reg   <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            rsp_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_TIMEOUT:  timeout_ticks_reg <= cfg_wdata;
                    CFG_AUTO_ACK: auto_ack_reg      <= cfg_wdata[0];
                    default:      auto_ack_reg      <= auto_ack_reg;
                endcase
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.opcode)
                            OP_SEND:
                            begin
                                retry_used_reg    <= 1'b0;
                                rx_count_reg      <= '0;
                                rx_sum_reg        <= '0;
                                timeout_count_reg <= '0;
                                phase_reg         <= 1'b1;
                                state_reg         <= T_FRAME;
                            end
                            OP_RX:
                            begin
                                if (phase_reg && !fail_now)
                                begin
                                    timeout_count_reg <= '0;
                                    ans_byte_reg      <= rx_byte;
                                    ans_index_reg     <= rx_count_reg;
                                    state_reg         <= T_ANSWER;
                                    if (rx_mode)
                                    begin
                                        ans_last_reg    <= 1'b0;
                                        ack_reg         <= auto_ack_reg &&
                                                           (rx_count_reg != '0);
                                        done_len_reg    <= count_inc[COUNT_W-1:0];
                                        done_status_reg <= 1'b0;
                                        phase_reg       <= 1'b0;
                                        rx_count_reg    <= '0;
                                        rx_sum_reg      <= '0;
                                    end
                                    else
                                    begin
                                        ans_last_reg <= 1'b1;
                                        rx_count_reg <= count_inc[COUNT_W-1:0];
                                        rx_sum_reg   <= rx_sum_reg + rx_byte;
                                    end
                                end
                            end
                            OP_TICK:
                            begin
                                if (phase_reg && !fail_now)
                                begin
                                    timeout_count_reg <= tick_next;
                                end
                            end
                            default:
                            begin
                                state_reg <= T_IDLE;
                            end
                        endcase

                        if (fail_now)
                        begin
                            rx_count_reg      <= '0;
                            rx_sum_reg        <= '0;
                            timeout_count_reg <= '0;
                            if (!retry_used_reg)
                            begin
                                retry_used_reg <= 1'b1;
                                state_reg      <= T_FRAME;
                            end
                            else
                            begin
                                phase_reg       <= 1'b0;
                                done_len_reg    <= '0;
                                done_status_reg <= 1'b1;
                                state_reg       <= T_DONE;
                            end
                        end
                    end
                end
                T_FRAME:
                begin
                    if (out_free && frame_stat.word_valid)
                    begin
                        rsp_reg <= pack_rsp(KIND_TX, frame_stat.word, '0, '0, '0, 1'b0,
                                            frame_stat.last);
                        if (frame_stat.last)
                        begin
                            state_reg <= T_IDLE;
                        end
                    end
                end
                T_ANSWER:
                begin
                    if (out_free)
                    begin
                        rsp_reg <= pack_rsp(KIND_ANSWER, '0, ans_byte_reg, ans_index_reg,
                                            '0, 1'b0, ans_last_reg);
                        if (ans_last_reg)
                        begin
                            state_reg <= T_IDLE;
                        end
                        else
                        begin
                            state_reg <= ack_reg ? T_ACK : T_DONE;
                        end
                    end
                end
                T_ACK:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= pack_rsp(KIND_TX, ACK_WORD, '0, '0, '0, 1'b0, 1'b0);
                        state_reg <= T_DONE;
                    end
                end
                T_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= pack_rsp(KIND_DONE, '0, '0, '0, done_len_reg,
                                              done_status_reg, 1'b1);
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    `MDB_ASSERT_IMPL(a_start_when_idle, frame_ctrl.start, !frame_stat.word_valid, "frame start while frame busy")
    `MDB_ASSERT_IMPL(a_load_when_idle, frame_ctrl.load_en, !frame_stat.word_valid, "store write during frame read")
    `MDB_ASSERT_IMPL(a_rx_clear, !phase_reg, (rx_count_reg == '0) && (rx_sum_reg == '0), "reply state not cleared")
    `MDB_ASSERT_NEXT(a_done_last, (state_reg == T_DONE) && out_free, rsp_valid && rsp.last, "done word not marked last")

endmodule
